FILE: design/hwd_pkg.sv
package hwd_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int CMP_W       = ID_W + 1;
    localparam int TIME_W      = 32;
    localparam int HEALTH_W    = 7;
    localparam int RST_W       = 4;
    localparam int PRIO_W      = 4;
    localparam int EVT_W       = 8;
    localparam int TIMEOUT_W   = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam int HEALTH_FULL     = 100;
    localparam int HEALTH_RESTART  = 75;
    localparam int FRESH_WINDOW    = 3;
    localparam int DECAY_PER_SEC   = 5;
    localparam int DECAY_LIMIT     = 26;
    localparam int PRIO_MIN        = 1;
    localparam int PRIO_MAX        = 10;
    localparam int TIMEOUT_RESET   = 5;
    localparam int MAX_RST_RESET   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESTARTS = 2'd1;

    typedef enum logic [2:0] {
        OP_CREATE    = 3'd0,
        OP_TERMINATE = 3'd1,
        OP_CRASH     = 3'd2,
        OP_HEARTBEAT = 3'd3,
        OP_SWEEP     = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        RS_OK         = 2'd0,
        RS_FULL       = 2'd1,
        RS_NO_ENTRY   = 2'd2,
        RS_TERMINATED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ES_RUNNING    = 2'd0,
        ES_CRASHED    = 2'd1,
        ES_TERMINATED = 2'd2
    } t_entry_state;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_DECODE = 2'd1,
        S_SW_RD  = 2'd2,
        S_SW_WR  = 2'd3
    } t_state;

    typedef struct packed {
        t_entry_state           state;
        logic [PRIO_W-1:0]      prio;
        logic                   crit;
        logic [RST_W-1:0]       restarts;
        logic [TIME_W-1:0]      last_beat;
        logic [HEALTH_W-1:0]    health;
    } t_entry;

    typedef struct packed {
        logic load;
        logic exec;
        logic sw_read;
        logic sw_write;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_sweep;
        logic table_empty;
        logic last_slot;
    } t_dp_stat;

endpackage

FILE: design/hwd_ctrl.sv
module hwd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hwd_pkg::t_dp_stat i_stat,
    output hwd_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    hwd_pkg::t_state r_state;
    hwd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hwd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            hwd_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = hwd_pkg::S_DECODE;
                end
            end
            hwd_pkg::S_DECODE: begin
                if (!i_stat.is_sweep) begin
                    o_cmd.exec = 1'b1;
                    n_state    = hwd_pkg::S_IDLE;
                end else if (i_stat.table_empty) begin
                    o_cmd.finish = 1'b1;
                    n_state      = hwd_pkg::S_IDLE;
                end else begin
                    n_state = hwd_pkg::S_SW_RD;
                end
            end
            hwd_pkg::S_SW_RD: begin
                o_cmd.sw_read = 1'b1;
                n_state       = hwd_pkg::S_SW_WR;
            end
            hwd_pkg::S_SW_WR: begin
                o_cmd.sw_write = 1'b1;
                if (i_stat.last_slot) begin
                    o_cmd.finish = 1'b1;
                    n_state      = hwd_pkg::S_IDLE;
                end else begin
                    n_state = hwd_pkg::S_SW_RD;
                end
            end
            default: begin
                n_state = hwd_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != hwd_pkg::S_IDLE);

endmodule

FILE: design/hwd_dp.sv
module hwd_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  hwd_pkg::t_dp_cmd                   i_cmd,
    output hwd_pkg::t_dp_stat                  o_stat,
    input  logic [2:0]                         i_operation,
    input  logic [hwd_pkg::ID_W-1:0]           i_pid,
    input  logic [hwd_pkg::PRIO_W-1:0]         i_priority_req,
    input  logic                               i_critical,
    input  logic [hwd_pkg::TIME_W-1:0]         i_now,
    input  logic                               i_cfg_we,
    input  logic [hwd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hwd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                               o_valid,
    output logic [1:0]                         o_status,
    output logic [hwd_pkg::ID_W-1:0]           o_new_pid,
    output logic [hwd_pkg::EVT_W-1:0]          o_watchdog_events,
    output logic [hwd_pkg::EVT_W-1:0]          o_restarts_done,
    output logic [hwd_pkg::EVT_W-1:0]          o_permanent_failures
);

    localparam int SLOT_W   = hwd_pkg::SLOT_W;
    localparam int CNT_W    = hwd_pkg::CNT_W;
    localparam int CMP_W    = hwd_pkg::CMP_W;
    localparam int ID_W     = hwd_pkg::ID_W;
    localparam int TIME_W   = hwd_pkg::TIME_W;
    localparam int HEALTH_W = hwd_pkg::HEALTH_W;
    localparam int RST_W    = hwd_pkg::RST_W;
    localparam int PRIO_W   = hwd_pkg::PRIO_W;
    localparam int EVT_W    = hwd_pkg::EVT_W;

    function automatic logic [HEALTH_W-1:0] health_step(
        input logic [HEALTH_W-1:0] h,
        input logic [TIME_W-1:0]   el
    );
        logic [HEALTH_W-1:0] dec;
        logic [HEALTH_W-1:0] res;
        dec = HEALTH_W'(el[4:0]) * HEALTH_W'(hwd_pkg::DECAY_PER_SEC);
        if (el < TIME_W'(hwd_pkg::FRESH_WINDOW)) begin
            res = (h >= HEALTH_W'(hwd_pkg::HEALTH_FULL)) ?
                  HEALTH_W'(hwd_pkg::HEALTH_FULL) : h + HEALTH_W'(1);
        end else if (el >= TIME_W'(hwd_pkg::DECAY_LIMIT)) begin
            res = '0;
        end else begin
            res = (h > dec) ? h - dec : '0;
        end
        return res;
    endfunction

    hwd_pkg::t_entry r_tab [hwd_pkg::TABLE_DEPTH];

    logic [2:0]                      r_op;
    logic [ID_W-1:0]                 r_pid;
    logic [PRIO_W-1:0]               r_prio;
    logic                            r_crit;
    logic [TIME_W-1:0]               r_now;
    logic [CNT_W-1:0]                r_count;
    logic [SLOT_W-1:0]               r_idx;
    logic [hwd_pkg::TIMEOUT_W-1:0]   r_timeout;
    logic [RST_W-1:0]                r_max_rst;
    hwd_pkg::t_entry                 r_cur;
    hwd_pkg::t_entry                 r_sel;
    logic [TIME_W-1:0]               r_elapsed;
    logic                            r_valid;
    hwd_pkg::t_status                r_status;
    logic [ID_W-1:0]                 r_new_pid;
    logic [EVT_W-1:0]                r_wd;
    logic [EVT_W-1:0]                r_rs;
    logic [EVT_W-1:0]                r_pf;

    hwd_pkg::t_status   n_status;
    logic [ID_W-1:0]    n_new_pid;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    hwd_pkg::t_entry    wr_data;
    logic               found;
    logic               full;
    logic [SLOT_W-1:0]  slot;
    hwd_pkg::t_entry    sel;
    logic [PRIO_W-1:0]  prio_clamped;
    hwd_pkg::t_entry    sw_entry;
    logic [TIME_W-1:0]  sw_el;
    logic               inc_wd;
    logic               inc_rs;
    logic               inc_pf;

    assign found = (r_pid != '0) && ({1'b0, r_pid} <= CMP_W'(r_count));
    assign full  = (r_count == CNT_W'(hwd_pkg::TABLE_DEPTH));
    assign slot  = SLOT_W'(r_pid - ID_W'(1));
    assign sel   = r_sel;

    always_comb begin
        if (r_prio < PRIO_W'(hwd_pkg::PRIO_MIN)) begin
            prio_clamped = PRIO_W'(hwd_pkg::PRIO_MIN);
        end else if (r_prio > PRIO_W'(hwd_pkg::PRIO_MAX)) begin
            prio_clamped = PRIO_W'(hwd_pkg::PRIO_MAX);
        end else begin
            prio_clamped = r_prio;
        end
    end

    // One table entry of the sweep: timeout, then restart or retire of a crashed critical entry, then health.
    always_comb begin
        sw_entry = r_cur;
        sw_el    = r_elapsed;
        inc_wd   = 1'b0;
        inc_rs   = 1'b0;
        inc_pf   = 1'b0;
        if (r_cur.state != hwd_pkg::ES_TERMINATED) begin
            if (r_cur.state == hwd_pkg::ES_RUNNING &&
                r_elapsed > TIME_W'(r_timeout)) begin
                sw_entry.state  = hwd_pkg::ES_CRASHED;
                sw_entry.health = '0;
                inc_wd          = 1'b1;
            end
            if (sw_entry.state == hwd_pkg::ES_CRASHED && r_cur.crit) begin
                if (r_cur.restarts >= r_max_rst) begin
                    sw_entry.state = hwd_pkg::ES_TERMINATED;
                    inc_pf         = 1'b1;
                end else begin
                    sw_entry.state     = hwd_pkg::ES_RUNNING;
                    sw_entry.restarts  = r_cur.restarts + RST_W'(1);
                    sw_entry.last_beat = r_now;
                    sw_entry.health    = HEALTH_W'(hwd_pkg::HEALTH_RESTART);
                    sw_el              = '0;
                    inc_rs             = 1'b1;
                end
            end
            if (sw_entry.state == hwd_pkg::ES_RUNNING) begin
                sw_entry.health = health_step(sw_entry.health, sw_el);
            end
        end
    end

    always_comb begin
        n_status  = hwd_pkg::RS_OK;
        n_new_pid = '0;
        wr_en     = 1'b0;
        wr_addr   = slot;
        wr_data   = sel;
        if (i_cmd.sw_write) begin
            wr_en   = 1'b1;
            wr_addr = r_idx;
            wr_data = sw_entry;
        end else if (i_cmd.exec) begin
            case (r_op)
                hwd_pkg::OP_CREATE: begin
                    if (full) begin
                        n_status = hwd_pkg::RS_FULL;
                    end else begin
                        wr_en             = 1'b1;
                        wr_addr           = SLOT_W'(r_count);
                        wr_data.state     = hwd_pkg::ES_RUNNING;
                        wr_data.prio      = prio_clamped;
                        wr_data.crit      = r_crit;
                        wr_data.restarts  = '0;
                        wr_data.last_beat = r_now;
                        wr_data.health    = HEALTH_W'(hwd_pkg::HEALTH_FULL);
                        n_new_pid         = ID_W'(r_count + CNT_W'(1));
                    end
                end
                hwd_pkg::OP_TERMINATE: begin
                    if (!found) begin
                        n_status = hwd_pkg::RS_NO_ENTRY;
                    end else begin
                        wr_en          = 1'b1;
                        wr_data.state  = hwd_pkg::ES_TERMINATED;
                        wr_data.health = '0;
                    end
                end
                hwd_pkg::OP_CRASH: begin
                    if (!found) begin
                        n_status = hwd_pkg::RS_NO_ENTRY;
                    end else if (sel.state == hwd_pkg::ES_TERMINATED) begin
                        n_status = hwd_pkg::RS_TERMINATED;
                    end else begin
                        wr_en          = 1'b1;
                        wr_data.state  = hwd_pkg::ES_CRASHED;
                        wr_data.health = '0;
                    end
                end
                hwd_pkg::OP_HEARTBEAT: begin
                    if (!found) begin
                        n_status = hwd_pkg::RS_NO_ENTRY;
                    end else if (sel.state == hwd_pkg::ES_TERMINATED) begin
                        n_status = hwd_pkg::RS_TERMINATED;
                    end else if (sel.state == hwd_pkg::ES_RUNNING) begin
                        wr_en             = 1'b1;
                        wr_data.last_beat = r_now;
                    end
                end
                default: begin
                    n_status = hwd_pkg::RS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_valid   <= 1'b0;
            r_timeout <= hwd_pkg::TIMEOUT_W'(hwd_pkg::TIMEOUT_RESET);
            r_max_rst <= RST_W'(hwd_pkg::MAX_RST_RESET);
        end else begin
            r_valid <= i_cmd.exec | i_cmd.finish;
            if (i_cmd.exec && r_op == hwd_pkg::OP_CREATE && !full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hwd_pkg::CFG_TIMEOUT:      r_timeout <= i_cfg_data;
                    hwd_pkg::CFG_MAX_RESTARTS: r_max_rst <= i_cfg_data[RST_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_pid     <= i_pid;
            r_prio    <= i_priority_req;
            r_crit    <= i_critical;
            r_now     <= i_now;
            r_sel     <= r_tab[SLOT_W'(i_pid - ID_W'(1))];
            r_idx     <= '0;
            r_status  <= hwd_pkg::RS_OK;
            r_new_pid <= '0;
            r_wd      <= '0;
            r_rs      <= '0;
            r_pf      <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_status  <= n_status;
                r_new_pid <= n_new_pid;
            end
            if (i_cmd.sw_read) begin
                r_cur     <= r_tab[r_idx];
                r_elapsed <= r_now - r_tab[r_idx].last_beat;
            end
            if (i_cmd.sw_write) begin
                r_idx <= r_idx + SLOT_W'(1);
                r_wd  <= r_wd + EVT_W'(inc_wd);
                r_rs  <= r_rs + EVT_W'(inc_rs);
                r_pf  <= r_pf + EVT_W'(inc_pf);
            end
        end
        if (wr_en) begin
            r_tab[wr_addr] <= wr_data;
        end
    end

    assign o_stat.is_sweep    = (r_op == hwd_pkg::OP_SWEEP);
    assign o_stat.table_empty = (r_count == '0);
    assign o_stat.last_slot   = (CNT_W'(r_idx) == r_count - CNT_W'(1));

    assign o_valid              = r_valid;
    assign o_status             = r_status;
    assign o_new_pid            = r_new_pid;
    assign o_watchdog_events    = r_wd;
    assign o_restarts_done      = r_rs;
    assign o_permanent_failures = r_pf;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(hwd_pkg::TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held longer than one cycle");

    a_create_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == hwd_pkg::OP_CREATE && !full)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("successful create did not add an entry");

    a_quiet_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != hwd_pkg::RS_OK)
        |-> (r_wd == '0 && r_rs == '0 && r_pf == '0 && r_new_pid == '0))
        else $error("failed operation reports nonzero counts or identifier");
`endif

endmodule

FILE: design/heartbeat_watchdog_supervisor_unit.sv
// Watchdog supervisor for a table of up to sixteen monitored entries. A command is
// taken when i_start is high and o_busy is low; its result word appears for exactly
// one cycle with o_valid and cannot be held off by the receiver. Create, terminate,
// crash and heartbeat execute in the decode state, where their result is registered,
// and the block is ready again in the cycle that shows the result. A check sweep
// reads each created entry in the sweep-read state and writes it back in the
// sweep-write state, one entry after another through the table. Configuration
// writes are accepted in every cycle and belong in idle periods.
module heartbeat_watchdog_supervisor_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [2:0]                      i_operation,
    input  logic [hwd_pkg::ID_W-1:0]        i_pid,
    input  logic [hwd_pkg::PRIO_W-1:0]      i_priority_req,
    input  logic                            i_critical,
    input  logic [hwd_pkg::TIME_W-1:0]      i_now,
    output logic                            o_valid,
    output logic [1:0]                      o_status,
    output logic [hwd_pkg::ID_W-1:0]        o_new_pid,
    output logic [hwd_pkg::EVT_W-1:0]       o_watchdog_events,
    output logic [hwd_pkg::EVT_W-1:0]       o_restarts_done,
    output logic [hwd_pkg::EVT_W-1:0]       o_permanent_failures,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hwd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hwd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    hwd_pkg::t_dp_cmd  cmd;
    hwd_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    hwd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    hwd_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_operation          (i_operation),
        .i_pid                (i_pid),
        .i_priority_req       (i_priority_req),
        .i_critical           (i_critical),
        .i_now                (i_now),
        .i_cfg_we             (i_cfg_valid & o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_valid              (o_valid),
        .o_status             (o_status),
        .o_new_pid            (o_new_pid),
        .o_watchdog_events    (o_watchdog_events),
        .o_restarts_done      (o_restarts_done),
        .o_permanent_failures (o_permanent_failures)
    );

endmodule
